// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and held off
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/iprt_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 prefix route table package
// Sizes, codes and the stored route layout shared by the table's modules.
// ----------------------------------------------------------------------------
package iprt_pkg;

  localparam int ROUTE_ENTRIES = 16;
  localparam int IDX_W         = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(ROUTE_ENTRIES + 1);

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ADD    = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ROUTE = 2'd1;
  localparam logic [1:0] ST_BAD_MASK = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
    logic [31:0] source;
    logic [31:0] gateway;
    logic [7:0]  port;
    logic        via_gateway;
  } route_t;

  localparam int ROUTE_W = $bits(route_t);

endpackage

// ===== rtl/ipv4_prefix_route_table_top.sv =====
// ----------------------------------------------------------------------------
// IPv4 prefix route table
// Bounded route store with longest-prefix-match lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata with the opcode in s_tuser.
//   An add item stores a route in the next free slot unless the netmask is not
//   a contiguous prefix or the table is full. A lookup item scans the stored
//   routes and returns the longest matching prefix, the later route winning
//   on equal length.
//   Every item yields exactly one result item on m_tvalid/m_tready/m_tdata,
//   with the status in m_tuser.
// Timing:
//   An add passes from S_IDLE to S_FINISH, which loads its result. A lookup
//   scans any stored routes in S_SCAN, reading the route memory one entry per
//   cycle through its single read port, then loads its result in S_FINISH. One
//   item is in work at a time; the next is accepted in the cycle after the
//   result is loaded, even while that result still waits.
// Reset:
//   Synchronous rst empties the table (count to zero) and drops any result.
//   Memory contents are not cleared; only entries below the count are read.
// Stall:
//   While m_tready is low the result is held and a finished item waits in
//   its final state, with s_tready low, until the result register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4_prefix_route_table_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] address, [63:32] netmask, [95:64] iface_addr, [103:96] iface_number,
  // [104] use_gateway, [136:105] gateway_addr, [143:137] zero
  input  logic [143:0] s_tdata,
  // [0] opcode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] out_iface_number, [39:8] next_hop, [71:40] source_addr
  output logic [71:0]  m_tdata,
  // [1:0] status
  output logic [1:0]   m_tuser
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  logic                       item_accept;
  logic [31:0]                in_address;
  logic [31:0]                in_netmask;
  logic [31:0]                in_iface_addr;
  logic [7:0]                 in_iface_number;
  logic                       in_use_gateway;
  logic [31:0]                in_gateway_addr;
  logic                       mask_ok;
  logic                       table_full;
  logic                       wr_en;
  logic                       rd_en;
  logic [iprt_pkg::IDX_W-1:0] rd_addr;
  logic                       issue_more;
  iprt_pkg::route_t           wr_route;
  iprt_pkg::route_t           rd_route;
  logic                       hit;
  logic                       better;

  logic [iprt_pkg::CNT_W-1:0] route_count;
  logic [iprt_pkg::CNT_W-1:0] rd_ptr;
  logic                       pend;
  logic                       found;
  logic [31:0]                lk_addr;
  logic [1:0]                 res_status;
  logic [31:0]                best_mask;
  logic [31:0]                best_source;
  logic [31:0]                best_gateway;
  logic [7:0]                 best_port;
  logic                       best_via;

  assign in_address      = s_tdata[31:0];
  assign in_netmask      = s_tdata[63:32];
  assign in_iface_addr   = s_tdata[95:64];
  assign in_iface_number = s_tdata[103:96];
  assign in_use_gateway  = s_tdata[104];
  assign in_gateway_addr = s_tdata[136:105];

  assign s_tready    = (state == S_IDLE);
  assign item_accept = s_tvalid && s_tready;

  // contiguous prefix: the ones below the lowest set bit fill the word
  assign mask_ok    = ((in_netmask | (in_netmask - 32'd1)) == iprt_pkg::ALL_ONES);
  assign table_full = (route_count == iprt_pkg::CNT_W'(iprt_pkg::ROUTE_ENTRIES));
  assign wr_en      = item_accept && (s_tuser == iprt_pkg::OP_ADD) && mask_ok && !table_full;

  assign wr_route.network     = in_address;
  assign wr_route.mask        = in_netmask;
  assign wr_route.source      = in_iface_addr;
  assign wr_route.gateway     = in_gateway_addr;
  assign wr_route.port        = in_iface_number;
  assign wr_route.via_gateway = in_use_gateway;

  assign issue_more = (state == S_SCAN) && (rd_ptr < route_count);
  assign rd_en      = (item_accept && (s_tuser == iprt_pkg::OP_LOOKUP) &&
                       (route_count != '0)) || issue_more;
  assign rd_addr    = (state == S_SCAN) ? rd_ptr[iprt_pkg::IDX_W-1:0] : '0;

  // later entries win on equal mask, hence the >=
  assign hit    = ((lk_addr & rd_route.mask) == rd_route.network);
  assign better = hit && (!found || (rd_route.mask >= best_mask));

  iprt_ram #(
    .WIDTH (iprt_pkg::ROUTE_W),
    .DEPTH (iprt_pkg::ROUTE_ENTRIES)
  ) u_route_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (route_count[iprt_pkg::IDX_W-1:0]),
    .wr_data (wr_route),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_route)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      route_count <= '0;
      rd_ptr      <= '0;
      pend        <= 1'b0;
      found       <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // a loading finish sets the valid itself
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_accept) begin
            found <= 1'b0;
            if (s_tuser == iprt_pkg::OP_ADD) begin
              if (!mask_ok) begin
                res_status <= iprt_pkg::ST_BAD_MASK;
              end else if (table_full) begin
                res_status <= iprt_pkg::ST_FULL;
              end else begin
                res_status <= iprt_pkg::ST_OK;
              end
              if (wr_en) begin
                route_count <= route_count + iprt_pkg::CNT_W'(1);
              end
              state <= S_FINISH;
            end else begin
              lk_addr    <= in_address;
              res_status <= iprt_pkg::ST_NO_ROUTE;
              if (route_count == '0) begin
                state <= S_FINISH;
              end else begin
                // entry 0 is already being read
                rd_ptr <= iprt_pkg::CNT_W'(1);
                pend   <= 1'b1;
                state  <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (pend && better) begin
            found        <= 1'b1;
            best_mask    <= rd_route.mask;
            best_source  <= rd_route.source;
            best_gateway <= rd_route.gateway;
            best_port    <= rd_route.port;
            best_via     <= rd_route.via_gateway;
          end
          pend <= issue_more;
          if (issue_more) begin
            rd_ptr <= rd_ptr + iprt_pkg::CNT_W'(1);
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the result register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (found) begin
              m_tuser        <= iprt_pkg::ST_OK;
              m_tdata[7:0]   <= best_port;
              m_tdata[39:8]  <= best_via ? best_gateway : lk_addr;
              m_tdata[71:40] <= best_source;
            end else begin
              m_tuser <= res_status;
              m_tdata <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst,
    route_count <= iprt_pkg::CNT_W'(iprt_pkg::ROUTE_ENTRIES), "route count beyond table size")

  `ASSERT_ALWAYS(a_write_room, clk, rst,
    !wr_en || !table_full, "route write into a full table")

  `ASSERT_NEXT(a_count_step, clk, rst, wr_en,
    route_count == $past(route_count) + iprt_pkg::CNT_W'(1), "route count not advanced on add")

  `ASSERT_NEXT(a_result_load, clk, rst, (state == S_FINISH) && (!m_tvalid || m_tready),
    m_tvalid && (state == S_IDLE), "finished item not loaded into result register")

endmodule

// ===== rtl/iprt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module iprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
